// File: hw/rtl/sjfs_pkg.sv
package sjfs_pkg;

    // field widths
    localparam int BURST_W = 16;
    localparam int ARR_W   = 16;
    localparam int TIME_W  = 21;
    localparam int SUM_W   = 25;
    localparam int PIDX_W  = 4;

    // input word: burst_time, arrival_time
    localparam int S_TDATA_W = 32;

    // output word layout, lowest bit up
    localparam int M_PIDX_LO  = 0;
    localparam int M_START_LO = M_PIDX_LO + PIDX_W;
    localparam int M_COMP_LO  = M_START_LO + TIME_W;
    localparam int M_WAIT_LO  = M_COMP_LO + TIME_W;
    localparam int M_TAT_LO   = M_WAIT_LO + TIME_W;
    localparam int M_TWAIT_LO = M_TAT_LO + TIME_W;
    localparam int M_TTAT_LO  = M_TWAIT_LO + SUM_W;
    localparam int M_USED_W   = M_TTAT_LO + SUM_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_WAIT,
        ST_PICK,
        ST_EMIT
    } sched_state_t;

    // outcome of one pass over the process table
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
        logic [TIME_W-1:0]  start_time;
    } scan_res_t;

endpackage

// File: hw/rtl/sjfs_ram.sv
module sjfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/sjfs_scan.sv
module sjfs_scan #(
    parameter int IDX_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clr,
    input  logic                      ent_vld,
    input  logic                      ent_done,
    input  logic [IDX_W-1:0]          ent_idx,
    input  logic [sjfs_pkg::BURST_W-1:0] ent_burst,
    input  logic [sjfs_pkg::ARR_W-1:0]   ent_arrival,
    input  logic [sjfs_pkg::TIME_W-1:0]  cur_time,
    output sjfs_pkg::scan_res_t       res,
    output logic [IDX_W-1:0]          res_idx
);
    import sjfs_pkg::*;

    // best arrived entry
    logic               fnd_reg;
    logic [BURST_W-1:0] b_burst_reg;
    logic [ARR_W-1:0]   b_arr_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    // earliest pending entry, shortest burst among equal arrivals
    logic               any_reg;
    logic [BURST_W-1:0] e_burst_reg;
    logic [ARR_W-1:0]   e_arr_reg;
    logic [IDX_W-1:0]   e_idx_reg;

    logic arrived;
    logic take_best;
    logic take_early;

    // compare one entry against both candidates
    always_comb begin
        arrived    = !ent_done && (TIME_W'(ent_arrival) <= cur_time);
        take_best  = ent_vld && arrived &&
                     (!fnd_reg || (ent_burst < b_burst_reg) ||
                      ((ent_burst == b_burst_reg) && (ent_arrival < b_arr_reg)));
        take_early = ent_vld && !ent_done &&
                     (!any_reg || (ent_arrival < e_arr_reg) ||
                      ((ent_arrival == e_arr_reg) && (ent_burst < e_burst_reg)));
    end

    // candidate flags
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            fnd_reg <= 1'b0;
            any_reg <= 1'b0;
        end else begin
            if (take_best) begin
                fnd_reg <= 1'b1;
            end
            if (take_early) begin
                any_reg <= 1'b1;
            end
        end
    end

    // candidate payload
    always_ff @(posedge aclk) begin
        if (take_best) begin
            b_burst_reg <= ent_burst;
            b_arr_reg   <= ent_arrival;
            b_idx_reg   <= ent_idx;
        end
        if (take_early) begin
            e_burst_reg <= ent_burst;
            e_arr_reg   <= ent_arrival;
            e_idx_reg   <= ent_idx;
        end
    end

    // best arrived entry starts now; idle CPU: time jumps to the earliest pending arrival
    always_comb begin
        if (fnd_reg) begin
            res.burst      = b_burst_reg;
            res.arrival    = b_arr_reg;
            res.start_time = cur_time;
            res_idx        = b_idx_reg;
        end else begin
            res.burst      = e_burst_reg;
            res.arrival    = e_arr_reg;
            res.start_time = TIME_W'(e_arr_reg);
            res_idx        = e_idx_reg;
        end
    end

endmodule

// File: hw/rtl/sjf_nonpreemptive_scheduler.sv
// Loading: one word per cycle; the word with s_tlast starts scheduling.
// For each result, the table is read once per entry through the single
// RAM port, the last read is left to land, then the scheduler picks and
// emits. A stalled output register holds the emit.
// Loading resumes once the last result is in the output register.
// aresetn is synchronous, active low, and clears the set.
module sjf_nonpreemptive_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // burst[15:0], arrival[31:16]
    input  logic [sjfs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // process_index[3:0], start_time[24:4], completion_time[45:25],
    // wait[66:46], turnaround_time[87:67], total_waiting[112:88],
    // total_turnaround[137:113], zero pad[143:138]
    output logic [sjfs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import sjfs_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int IDX_EXT_W = IDX_W + PIDX_W;

    sched_state_t state_reg, state_next;

    logic [CNT_W-1:0]     loaded_cnt_reg;
    logic [CNT_W-1:0]     emit_cnt_reg;
    logic [IDX_W-1:0]     scan_cnt_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [MAX_PROCS-1:0] done_reg;
    logic [TIME_W-1:0]    cur_time_reg;
    logic [SUM_W-1:0]     wsum_reg, wsum_next;
    logic [SUM_W-1:0]     tsum_reg, tsum_next;

    logic [IDX_W-1:0]     pick_idx_reg;
    logic [TIME_W-1:0]    start_reg, comp_reg, wait_reg, tat_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 s_fire;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [S_TDATA_W-1:0] ram_rdata;
    logic [CNT_W-1:0]     last_addr;
    logic                 last_issue;
    logic                 out_free;
    logic                 is_final;
    logic                 emit_go;
    logic                 scan_clr;
    logic [TIME_W-1:0]    comp_calc, wait_calc, tat_calc;
    logic [IDX_EXT_W-1:0] pidx_ext;

    scan_res_t            scan_res;
    logic [IDX_W-1:0]     scan_idx;

    // control
    always_comb begin
        s_tready   = (state_reg == ST_LOAD);
        s_fire     = s_tvalid && s_tready;
        ram_we     = s_fire && (loaded_cnt_reg < CNT_W'(MAX_PROCS));
        ram_addr   = (state_reg == ST_LOAD) ? loaded_cnt_reg[IDX_W-1:0] : scan_cnt_reg;
        last_addr  = loaded_cnt_reg - CNT_W'(1);
        last_issue = (scan_cnt_reg == last_addr[IDX_W-1:0]);
        out_free   = !m_tvalid_reg || m_tready;
        is_final   = ((emit_cnt_reg + CNT_W'(1)) == loaded_cnt_reg);
        emit_go    = (state_reg == ST_EMIT) && out_free;
        scan_clr   = (state_reg == ST_SCAN) && (scan_cnt_reg == '0);

        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_PICK;
            ST_PICK: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = is_final ? ST_LOAD : ST_SCAN;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // timing of the chosen process
    always_comb begin
        comp_calc = scan_res.start_time + TIME_W'(scan_res.burst);
        wait_calc = scan_res.start_time - TIME_W'(scan_res.arrival);
        tat_calc  = comp_calc - TIME_W'(scan_res.arrival);
        wsum_next = wsum_reg + SUM_W'(wait_reg);
        tsum_next = tsum_reg + SUM_W'(tat_reg);
        pidx_ext  = IDX_EXT_W'(pick_idx_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            loaded_cnt_reg <= '0;
            emit_cnt_reg   <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            done_reg       <= '0;
            cur_time_reg   <= '0;
            wsum_reg       <= '0;
            tsum_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);

            if (ram_we) begin
                loaded_cnt_reg <= loaded_cnt_reg + CNT_W'(1);
            end

            if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= last_issue ? '0 : scan_cnt_reg + IDX_W'(1);
            end

            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // retire the chosen process; the set clears after its last word
            if (emit_go) begin
                if (is_final) begin
                    loaded_cnt_reg <= '0;
                    emit_cnt_reg   <= '0;
                    done_reg       <= '0;
                    cur_time_reg   <= '0;
                    wsum_reg       <= '0;
                    tsum_reg       <= '0;
                end else begin
                    emit_cnt_reg           <= emit_cnt_reg + CNT_W'(1);
                    done_reg[pick_idx_reg] <= 1'b1;
                    cur_time_reg           <= comp_reg;
                    wsum_reg               <= wsum_next;
                    tsum_reg               <= tsum_next;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_cnt_reg;
        if (state_reg == ST_PICK) begin
            pick_idx_reg <= scan_idx;
            start_reg    <= scan_res.start_time;
            comp_reg     <= comp_calc;
            wait_reg     <= wait_calc;
            tat_reg      <= tat_calc;
        end
        if (emit_go) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, tsum_next, wsum_next, tat_reg, wait_reg,
                            comp_reg, start_reg, pidx_ext[PIDX_W-1:0]};
            m_tlast_reg <= is_final;
        end
    end

    // process table: burst in the low half, arrival in the high half
    sjfs_ram #(
        .WIDTH (S_TDATA_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    sjfs_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clr         (scan_clr),
        .ent_vld     (rd_vld_reg),
        .ent_done    (done_reg[rd_idx_reg]),
        .ent_idx     (rd_idx_reg),
        .ent_burst   (ram_rdata[BURST_W-1:0]),
        .ent_arrival (ram_rdata[S_TDATA_W-1:BURST_W]),
        .cur_time    (cur_time_reg),
        .res         (scan_res),
        .res_idx     (scan_idx)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: hw/rtl/sjfs_checker.sv
module sjfs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sjfs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sjfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import sjfs_pkg::*;

    logic s_fire;
    logic [TIME_W-1:0] run_a, run_b;

    assign s_fire = s_tvalid && s_tready;
    assign run_a  = m_tdata[M_COMP_LO +: TIME_W] - m_tdata[M_START_LO +: TIME_W];
    assign run_b  = m_tdata[M_TAT_LO +: TIME_W] - m_tdata[M_WAIT_LO +: TIME_W];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // the closing word of a set starts scheduling and stops loading
    a_load_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> !s_tready)
        else $error("input still ready after last process");

    // loading keeps going until the closing word
    a_load_on: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_tlast |=> s_tready)
        else $error("input stalled during loading");

    // burst is both completion minus start and turnaround minus waiting
    a_times: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> run_a == run_b)
        else $error("inconsistent result times");

endmodule

bind sjf_nonpreemptive_scheduler sjfs_checker u_sjfs_checker (.*);

// File: tb/sv/sjf_nonpreemptive_scheduler_test.sv
module sjf_nonpreemptive_scheduler_test;
    import sjfs_pkg::*;

    localparam int MAX_PROCS   = 16;
    localparam int HALF_PERIOD = 10;
    localparam int RUN_LIMIT   = 4_000_000;
    localparam int SETTLE_CYC  = 100;
    localparam int REPORT_MAX  = 10;

    // one scheduled process as seen on the result stream
    typedef struct packed {
        logic [PIDX_W-1:0] idx;
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] finish_t;
        logic [TIME_W-1:0] wait_t;
        logic [TIME_W-1:0] turn_t;
        logic [SUM_W-1:0]  wait_sum;
        logic [SUM_W-1:0]  turn_sum;
        logic              last_flag;
    } sched_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // process table as loaded so far, and schedule rows still owed by the block
    logic [BURST_W-1:0] tbl_burst[$];
    logic [ARR_W-1:0]   tbl_arrival[$];
    sched_row_t         owed_rows[$];

    int err_cnt    = 0;
    int items_sent = 0;

    // traffic shaping knobs
    bit gaps_on    = 1'b1;
    bit rx_stalls  = 1'b1;
    int burst_left = 0;
    int rx_hold    = 0;
    bit rx_phase   = 1'b1;
    int rx_run     = 0;

    sjf_nonpreemptive_scheduler #(
        .MAX_PROCS (MAX_PROCS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // shorter burst wins, then earlier arrival; scan order settles the index tie
    function automatic bit preferred(int a, int b);
        if (tbl_burst[a] != tbl_burst[b])
            return tbl_burst[a] < tbl_burst[b];
        return tbl_arrival[a] < tbl_arrival[b];
    endfunction

    // best arrived, unfinished process at time now
    function automatic bit pick_ready(input bit [MAX_PROCS-1:0] done,
                                      input logic [TIME_W-1:0] now,
                                      output int pick);
        bit found;
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < tbl_burst.size(); i++) begin
            if (!done[i] && tbl_arrival[i] <= now && (!found || preferred(i, pick))) begin
                pick  = i;
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // run SJF over the loaded table and queue one row per process
    function automatic void plan_schedule();
        int                  n;
        int                  pick;
        int                  first;
        bit [MAX_PROCS-1:0]  done;
        logic [TIME_W-1:0]   now;
        logic [SUM_W-1:0]    wsum;
        logic [SUM_W-1:0]    tsum;
        sched_row_t          row;
        n    = tbl_burst.size();
        done = '0;
        now  = '0;
        wsum = '0;
        tsum = '0;
        for (int k = 0; k < n; k++) begin
            if (!pick_ready(done, now, pick)) begin
                // CPU idle: jump to the earliest pending arrival
                first = -1;
                for (int i = 0; i < n; i++) begin
                    if (!done[i] && (first < 0 || tbl_arrival[i] < tbl_arrival[first]))
                        first = i;
                end
                now = TIME_W'(tbl_arrival[first]);
                void'(pick_ready(done, now, pick));
            end
            row.idx       = PIDX_W'(pick);
            row.start_t   = now;
            row.finish_t  = now + TIME_W'(tbl_burst[pick]);
            row.wait_t    = now - TIME_W'(tbl_arrival[pick]);
            row.turn_t    = row.finish_t - TIME_W'(tbl_arrival[pick]);
            wsum          = wsum + SUM_W'(row.wait_t);
            tsum          = tsum + SUM_W'(row.turn_t);
            row.wait_sum  = wsum;
            row.turn_sum  = tsum;
            row.last_flag = (k == n - 1);
            now           = row.finish_t;
            done[pick]    = 1'b1;
            owed_rows.push_back(row);
        end
        tbl_burst.delete();
        tbl_arrival.delete();
    endfunction

    // offer one process word, account for it once accepted
    task automatic send_proc(input logic [BURST_W-1:0] burst,
                             input logic [ARR_W-1:0] arrival, input logic last);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {arrival, burst};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // a full table drops the word but still honors its last mark
        if (tbl_burst.size() < MAX_PROCS) begin
            tbl_burst.push_back(burst);
            tbl_arrival.push_back(arrival);
        end
        if (last)
            plan_schedule();
        items_sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 7);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end
        end
    endtask

    // stop offering and wait for every owed row
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (owed_rows.size() != 0) @(posedge aclk);
    endtask

    // receiver: long hold-off when asked, else random ready/stall runs
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_phase = !rx_phase;
                rx_run   = rx_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_run--;
            m_tready <= rx_phase;
        end
    end

    // result checker: each accepted word against the oldest owed row
    always @(posedge aclk) begin
        sched_row_t got;
        sched_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx       = m_tdata[M_PIDX_LO  +: PIDX_W];
            got.start_t   = m_tdata[M_START_LO +: TIME_W];
            got.finish_t  = m_tdata[M_COMP_LO  +: TIME_W];
            got.wait_t    = m_tdata[M_WAIT_LO  +: TIME_W];
            got.turn_t    = m_tdata[M_TAT_LO   +: TIME_W];
            got.wait_sum  = m_tdata[M_TWAIT_LO +: SUM_W];
            got.turn_sum  = m_tdata[M_TTAT_LO  +: SUM_W];
            got.last_flag = m_tlast;
            if (owed_rows.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX)
                    $display("unexpected result word: idx %0d start %0d", got.idx,
                             got.start_t);
            end else begin
                want = owed_rows.pop_front();
                if (got !== want || m_tdata[M_TDATA_W-1:M_USED_W] !== '0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX) begin
                        $display({"mismatch exp: idx %0d st %0d ct %0d wt %0d tat %0d",
                                  " sw %0d st %0d l %0d"},
                                 want.idx, want.start_t, want.finish_t, want.wait_t,
                                 want.turn_t, want.wait_sum, want.turn_sum, want.last_flag);
                        $display({"         got: idx %0d st %0d ct %0d wt %0d tat %0d",
                                  " sw %0d st %0d l %0d pad %0h"},
                                 got.idx, got.start_t, got.finish_t, got.wait_t,
                                 got.turn_t, got.wait_sum, got.turn_sum, got.last_flag,
                                 m_tdata[M_TDATA_W-1:M_USED_W]);
                    end
                end
            end
        end
    end

    // field extremes: zero everything, and a lone late process with max burst
    task automatic test_single_process();
        send_proc(16'd0, 16'd0, 1'b1);
        send_proc(16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    // equal bursts go to the earlier arrival, then to the lower index
    task automatic test_tie_breaks();
        send_proc(16'd10, 16'd0, 1'b0);
        send_proc(16'd4, 16'd3, 1'b0);
        send_proc(16'd4, 16'd1, 1'b0);
        send_proc(16'd4, 16'd1, 1'b1);
    endtask

    // CPU goes idle twice waiting for later arrivals
    task automatic test_idle_cpu();
        send_proc(16'd3, 16'd10, 1'b0);
        send_proc(16'd2, 16'd50, 1'b0);
        send_proc(16'd1, 16'd0, 1'b1);
    endtask

    // 17th word overflows the table and is dropped, its last mark still starts scheduling
    task automatic test_store_full();
        for (int i = 0; i <= MAX_PROCS; i++)
            send_proc((i % 3 == 0) ? 16'hFFFF : 16'($urandom), 16'($urandom), i == MAX_PROCS);
    endtask

    // receiver holds off while a second set is offered, then the sender waits out the drain
    task automatic test_backpressure();
        gaps_on = 1'b0;
        rx_hold = 400;
        for (int i = 0; i < 8; i++)
            send_proc(16'($urandom_range(1, 30)), 16'($urandom_range(0, 60)), i == 7);
        for (int i = 0; i < 6; i++)
            send_proc(16'($urandom_range(1, 30)), 16'($urandom_range(0, 60)), i == 5);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // random sets: mostly small, some full or overflowing, several timing styles
    task automatic test_random_sets();
        int                 n;
        int                 style;
        int                 start_cnt;
        logic [BURST_W-1:0] b;
        logic [ARR_W-1:0]   a;
        start_cnt = items_sent;
        while (items_sent - start_cnt < 60) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(MAX_PROCS, MAX_PROCS + 2);
                1, 2:    n = $urandom_range(7, MAX_PROCS - 1);
                default: n = $urandom_range(1, 6);
            endcase
            style = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                case (style)
                    0: begin  // crowded start, many ties
                        b = BURST_W'($urandom_range(0, 15));
                        a = ARR_W'($urandom_range(0, 15));
                    end
                    1: begin  // full range
                        b = BURST_W'($urandom);
                        a = ARR_W'($urandom);
                    end
                    2: begin  // short jobs spread out, CPU idles
                        b = BURST_W'($urandom_range(0, 40));
                        a = ARR_W'($urandom_range(0, 4000));
                    end
                    default: begin
                        b = BURST_W'($urandom_range(0, 1000));
                        a = ARR_W'($urandom_range(0, 3000));
                    end
                endcase
                send_proc(b, a, i == n - 1);
            end
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        rx_stalls = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_single_process();
        test_tie_breaks();
        test_idle_cpu();
        test_store_full();
        test_backpressure();
        test_random_sets();
        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (err_cnt == 0 && owed_rows.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
